// ===== rtl/upqs_pkg.sv =====
// shared types and constants of the udp port queue steering core
// no dependencies; imported by upqs_parse and udp_port_queue_steering_core
`default_nettype none

package upqs_pkg;

    // sizes
    localparam int QUEUES_DEFAULT = 64;
    localparam int CNT_W          = 64;
    localparam int PORT_W         = 16;
    localparam int QID_W          = 8;
    localparam int OFF_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_FIFO_AW    = 2;
    localparam int M_TDATA_W      = 80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FABRIC_PORT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_QUEUES = 2'd1;

    localparam logic [PORT_W-1:0]     FABRIC_PORT_RST  = 16'd4789;
    localparam logic [CFG_DATA_W-1:0] BOUND_QUEUES_RST = '0;

    // frame offsets
    localparam logic [OFF_W-1:0] OFF_ETYPE_HI = 7'd12;
    localparam logic [OFF_W-1:0] OFF_ETYPE_LO = 7'd13;
    localparam logic [OFF_W-1:0] OFF_IHL      = 7'd14;
    localparam logic [OFF_W-1:0] OFF_PROTO    = 7'd23;
    localparam logic [OFF_W-1:0] OFF_MAX      = 7'd127;
    // udp dest port at 14 + 4*ihl + 2, frame end needed at 14 + 4*ihl + 8
    localparam logic [7:0]       DPORT_BASE   = 8'd16;
    localparam logic [7:0]       UDP_END_BASE = 8'd22;
    localparam logic [7:0]       MIN_LEN      = 8'd34;

    localparam logic [7:0] ETYPE_HI  = 8'h08;
    localparam logic [7:0] ETYPE_LO  = 8'h00;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // match flag bits
    localparam int FLAG_ETH     = 0;
    localparam int FLAG_PROTO   = 1;
    localparam int FLAG_PORT_HI = 2;
    localparam int FLAG_PORT_LO = 3;
    localparam int FLAG_W       = 4;

    // end-of-frame report from the parser
    typedef struct packed {
        logic eof;
        logic hit;
    } t_frame_end;

    // one result word
    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic             matched;
        logic [QID_W-1:0] queue;
        logic             verdict;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/udp_port_queue_steering_core.sv =====
// top level of the udp port queue steering core: parser, counter memory, result fifo
// depends on upqs_pkg and upqs_parse
`default_nettype none

// usage
//   s_axis: one frame byte per word, from the destination mac on; tlast marks
//     the last byte, tuser carries the receive queue (the value with the last
//     byte counts). bytes are taken back to back, one per cycle, while s_axis_tready is high.
//   m_axis: one result word per frame, after its last byte: verdict, queue,
//     matched flag and, for a counted match, the queue's updated 64-bit counter (else zero).
//   cfg: write channel, index 0 fabric udp port, index 1 bound-queue mask; always
//     ready; the user must see it written only while the block is idle; not enforced.
// order: the counter memory is read into the update stage registers as the last
//   byte is taken; from there the incremented count is written back and the
//   result word is pushed into the result fifo, whose head drives m_axis.
// throughput: one byte per cycle while s_axis_tready is high; one result per cycle
//   at most, for frames of one byte each. a counter update is a read-modify-write
//   on a memory with one read and one write port; a write in flight is forwarded
//   to a read of the same queue.
// reset: counters read as zero through per-queue valid bits cleared at once,
//   config returns to port 4789 and an empty mask; no clearing pass.
// stall: results queue in a 4-word fifo; s_axis_tready drops only when the
//   fifo plus the word in the update stage would fill it.
module udp_port_queue_steering_core
    import upqs_pkg::*;
#(
    parameter int NUM_QUEUES = QUEUES_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // frame bytes
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  s_axis_tlast,   // last_byte
    input  wire logic [QID_W-1:0]      s_axis_tuser,   // [7:0] rx_queue
    // verdicts
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] verdict, [8:1] queue, [9] matched, [73:10] match_count, [79:74] zero
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // configuration registers
    logic [PORT_W-1:0]     r_fabric_port;
    logic [CFG_DATA_W-1:0] r_bound;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fabric_port <= FABRIC_PORT_RST;
            r_bound       <= BOUND_QUEUES_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FABRIC_PORT:  r_fabric_port <= i_cfg_data[PORT_W-1:0];
                CFG_BOUND_QUEUES: r_bound       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // header parsing
    logic       in_acc;
    t_frame_end frame_end;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    upqs_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_port  (r_fabric_port),
        .o_end   (frame_end)
    );

    // stage 0: decide counting, issue counter read
    logic          q_in_range;
    logic          rd_en;
    logic [QW-1:0] rd_addr;

    assign q_in_range = ({1'b0, s_axis_tuser} < 9'(NUM_QUEUES));
    assign rd_en      = frame_end.eof && frame_end.hit && q_in_range;
    assign rd_addr    = s_axis_tuser[QW-1:0];

    // counter memory with per-queue valid bits for the zero reset
    logic [CNT_W-1:0]      mem_cnt [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_cnt_vld;
    logic [CNT_W-1:0]      r_rd_data;

    // stage 1 registers
    logic             r_s1_valid;
    logic             r_s1_counted;
    logic             r_s1_redirect;
    logic [QID_W-1:0] r_s1_queue;
    logic [QW-1:0]    r_s1_addr;
    logic             r_s1_vld;
    logic             r_s1_fwd;
    logic [CNT_W-1:0] r_fwd_data;

    logic             wr_en;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_sum;

    assign wr_en    = r_s1_valid && r_s1_counted;
    // a write of the previous cycle to the same queue wins over the stale read
    assign cnt_base = r_s1_fwd ? r_fwd_data : (r_s1_vld ? r_rd_data : '0);
    assign cnt_sum  = cnt_base + 64'd1;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem_cnt[rd_addr];
        end
        if (wr_en) begin
            mem_cnt[r_s1_addr] <= cnt_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (wr_en) begin
            r_cnt_vld[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= frame_end.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_end.eof) begin
            r_s1_counted  <= rd_en;
            r_s1_redirect <= rd_en && r_bound[s_axis_tuser[5:0]];
            r_s1_queue    <= s_axis_tuser;
            r_s1_addr     <= rd_addr;
            r_s1_vld      <= r_cnt_vld[rd_addr];
            r_s1_fwd      <= wr_en && (r_s1_addr == rd_addr);
            r_fwd_data    <= cnt_sum;
        end
    end

    // result fifo
    t_result                r_fifo [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_AW-1:0] r_wr_ptr;
    logic [OUT_FIFO_AW-1:0] r_rd_ptr;
    logic [OUT_FIFO_AW:0]   r_fifo_cnt;
    logic                   push;
    logic                   pop;
    t_result                s1_res;
    t_result                head;

    assign push = r_s1_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb begin
        s1_res.verdict     = r_s1_redirect;
        s1_res.queue       = r_s1_queue;
        s1_res.matched     = r_s1_counted;
        s1_res.match_count = r_s1_counted ? cnt_sum : '0;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + 1'b1;
                2'b01:   r_fifo_cnt <= r_fifo_cnt - 1'b1;
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
    end

    // room for the word in the update stage plus one more
    assign s_axis_tready =
        (({1'b0, r_fifo_cnt} + {{(OUT_FIFO_AW + 1){1'b0}}, r_s1_valid})
         < (OUT_FIFO_AW + 2)'(OUT_FIFO_DEPTH));

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_fifo_cnt != '0);
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, head};

    // checks
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_fifo_cnt} + {{(OUT_FIFO_AW + 1){1'b0}}, r_s1_valid})
            <= (OUT_FIFO_AW + 2)'(OUT_FIFO_DEPTH))
        else $error("result fifo overrun");

    a_redirect_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9])
        else $error("redirect without a counted match");

    a_match_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> ({1'b0, m_axis_tdata[8:1]} < 9'(NUM_QUEUES)))
        else $error("match reported for a queue out of range");

    a_fwd_same_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en && wr_en && (r_s1_addr == rd_addr) |=> r_s1_fwd)
        else $error("back-to-back update of one queue not forwarded");

endmodule

`default_nettype wire

// ===== rtl/upqs_parse.sv =====
// byte-serial header parser: ethertype, ipv4 protocol, udp dest port and length match
// depends on upqs_pkg
`default_nettype none

module upqs_parse
    import upqs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    input  wire logic [PORT_W-1:0] i_port,
    output t_frame_end             o_end
);

    logic [OFF_W-1:0]  r_off;
    logic [3:0]        r_hlw;
    logic [FLAG_W-1:0] r_flags;
    logic [3:0]        n_hlw;
    logic [FLAG_W-1:0] n_flags;
    logic [7:0]        port_off;
    logic [7:0]        need;
    logic [7:0]        off_ext;

    always_comb begin
        n_flags = r_flags;
        n_hlw   = r_hlw;
        off_ext = {1'b0, r_off};
        if (r_off == OFF_ETYPE_HI) begin
            n_flags[FLAG_ETH] = (i_byte == ETYPE_HI);
        end else if (r_off == OFF_ETYPE_LO && i_byte != ETYPE_LO) begin
            n_flags[FLAG_ETH] = 1'b0;
        end
        if (r_off == OFF_IHL) begin
            n_hlw = i_byte[3:0];
        end
        if (r_off == OFF_PROTO) begin
            n_flags[FLAG_PROTO] = (i_byte == PROTO_UDP);
        end
        port_off = DPORT_BASE + {2'b00, n_hlw, 2'b00};
        if (off_ext == port_off) begin
            n_flags[FLAG_PORT_HI] = (i_byte == i_port[15:8]);
        end else if (off_ext == port_off + 8'd1) begin
            n_flags[FLAG_PORT_LO] = (i_byte == i_port[7:0]);
        end
        need = UDP_END_BASE + {2'b00, n_hlw, 2'b00};
        if (need < MIN_LEN) begin
            need = MIN_LEN;
        end
        o_end.eof = i_valid && i_last;
        o_end.hit = (&n_flags) && ((off_ext + 8'd1) >= need);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_hlw   <= '0;
            r_flags <= '0;
        end else if (i_valid) begin
            if (i_last) begin
                r_off   <= '0;
                r_hlw   <= '0;
                r_flags <= '0;
            end else begin
                if (r_off != OFF_MAX) begin
                    r_off <= r_off + 7'd1;
                end
                r_hlw   <= n_hlw;
                r_flags <= n_flags;
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/udp_port_queue_steering_core_tb.sv =====
// self-checking testbench of udp_port_queue_steering_core: byte stream in, one verdict per frame
// depends on upqs_pkg and the core rtl; a behavioral predictor inside supplies the expected words
`timescale 1ns / 1ps

module udp_port_queue_steering_core_tb;
    import upqs_pkg::*;

    // run shape
    localparam int N_Q            = QUEUES_DEFAULT;
    localparam int RES_W          = $bits(t_result);
    localparam int RAND_BYTES     = 250;
    localparam int RAND_FRAMES    = 8;
    localparam int CFG_EVERY      = 3;
    localparam int HOLD_AT_FRAME  = 2;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_SLACK    = 4;
    localparam int CYCLE_LIMIT    = 600000;

    // frame layout as the classifier sees it
    localparam int ETYPE_HI_AT = 12;
    localparam int ETYPE_LO_AT = 13;
    localparam int IHL_AT      = 14;
    localparam int PROTO_AT    = 23;
    localparam int DPORT_BASE_AT = 16;    // plus 4*ihl
    localparam int UDP_END_BASE  = 22;    // plus 4*ihl
    localparam int MIN_FRAME     = 34;

    localparam logic [15:0] IPV4_ETYPE = 16'h0800;
    localparam logic [7:0]  UDP_PROTO  = 8'd17;
    localparam logic [15:0] VXLAN_PORT = 16'd4789;

    // match flag bits of the predictor
    localparam int F_ETH  = 0;
    localparam int F_PROT = 1;
    localparam int F_PHI  = 2;
    localparam int F_PLO  = 3;

    // register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_FRAME, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} t_rx_mode;

    // one line of the directed table
    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic [7:0]              len;
        logic [3:0]              ihl;
        logic [15:0]             etype;
        logic [7:0]              proto;
        logic [15:0]             dport;
        logic [QID_W-1:0]        queue;
        logic                    typed;     // res below is the literal expectation
        t_result                 res;
    } t_step_row;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;    // [7:0] data_byte
    logic                  s_axis_tlast;    // last_byte
    logic [QID_W-1:0]      s_axis_tuser;    // [7:0] rx_queue
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] verdict, [8:1] queue, [9] matched, [73:10] match_count, [79:74] zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state: configuration, frame parse state, per-queue hit counters
    logic [15:0]           port_cfg;
    logic [63:0]           bound_cfg;
    logic [6:0]            fr_pos;
    logic [3:0]            fr_ihl;
    logic [3:0]            fr_flags;
    logic [CNT_W-1:0]      queue_hits [N_Q];

    t_result               verdict_due [$];   // verdicts predicted, not yet seen
    logic [7:0]            frame_buf [$];     // bytes of the frame about to go out
    t_step_row             step_rows [$];

    int                    mismatch_cnt = 0;
    int unsigned           cycle_cnt = 0;
    int                    tx_burst_left = 0;
    bit                    tx_gapless = 1'b0;
    int                    rx_hold_asks = 0;
    int                    rx_hold_done = 0;

    udp_port_queue_steering_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // classifier predictor: takes one accepted byte, returns 1 with the verdict on a last byte
    function automatic logic steer_byte(input logic [7:0] b, input logic last,
                                        input logic [QID_W-1:0] q, output t_result res);
        int off;
        int dport_at;
        int need;
        logic hit;
        off = fr_pos;
        res = '0;
        // ethertype: high byte sets or clears, a wrong low byte only clears
        if (off == ETYPE_HI_AT)
            fr_flags[F_ETH] = (b == IPV4_ETYPE[15:8]);
        else if (off == ETYPE_LO_AT && b != IPV4_ETYPE[7:0])
            fr_flags[F_ETH] = 1'b0;
        if (off == IHL_AT)
            fr_ihl = b[3:0];
        if (off == PROTO_AT)
            fr_flags[F_PROT] = (b == UDP_PROTO);
        // udp destination port moves with the ihl seen so far
        dport_at = DPORT_BASE_AT + 4 * fr_ihl;
        if (off == dport_at)
            fr_flags[F_PHI] = (b == port_cfg[15:8]);
        else if (off == dport_at + 1)
            fr_flags[F_PLO] = (b == port_cfg[7:0]);
        if (!last) begin
            if (fr_pos != 7'd127)
                fr_pos = fr_pos + 7'd1;
            return 1'b0;
        end
        need = UDP_END_BASE + 4 * fr_ihl;
        if (need < MIN_FRAME)
            need = MIN_FRAME;
        hit = (&fr_flags) && (off + 1 >= need);
        res.queue = q;
        if (hit && q < N_Q) begin
            queue_hits[q] = queue_hits[q] + 64'd1;
            res.matched     = 1'b1;
            res.match_count = queue_hits[q];
            res.verdict     = bound_cfg[q];
        end
        fr_pos   = '0;
        fr_ihl   = '0;
        fr_flags = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    // compare one result word against the oldest prediction
    task automatic check_verdict(input logic [M_TDATA_W-1:0] word);
        t_result got;
        t_result want;
        got = word[RES_W-1:0];
        if (verdict_due.size() == 0) begin
            report_mismatch("word with nothing due", word[63:0], '0);
            return;
        end
        want = verdict_due.pop_front();
        if (got.verdict !== want.verdict)
            report_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
        if (got.queue !== want.queue)
            report_mismatch("queue", 64'(got.queue), 64'(want.queue));
        if (got.matched !== want.matched)
            report_mismatch("matched", 64'(got.matched), 64'(want.matched));
        if (got.match_count !== want.match_count)
            report_mismatch("match_count", got.match_count, want.match_count);
        if (word[M_TDATA_W-1:RES_W] !== '0)
            report_mismatch("padding", 64'(word[M_TDATA_W-1:RES_W]), '0);
    endtask

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            check_verdict(m_axis_tdata);
    end

    // receiver: new random stall pattern whenever rx_tick is a multiple of 64, long hold-off on request
    initial begin : rx_side
        int unsigned rx_tick;
        t_rx_mode    rx_mode;
        logic [31:0] rnd;
        rx_tick = 0;
        rx_mode = RX_OPEN;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_asks != rx_hold_done) begin
                // hold off long enough for the result fifo to back up into s_axis
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_done++;
            end
            rnd = $urandom;
            if (rx_tick % 64 == 0)
                rx_mode = t_rx_mode'(rnd[9:8]);
            case (rx_mode)
                RX_OPEN:   m_axis_tready = 1'b1;
                RX_COIN:   m_axis_tready = rnd[0];
                RX_SPARSE: m_axis_tready = (rnd[1:0] == 2'd0);
                default:   m_axis_tready = (rx_tick % 5 != 4);
            endcase
            rx_tick++;
        end
    end

    // fill frame_buf with random bytes, then place the header fields that fit
    function automatic void build_frame(input int len, input int ihl, input logic [15:0] etype,
                                        input logic [7:0] proto, input logic [15:0] dport);
        logic [31:0] rnd;
        int          at;
        frame_buf.delete();
        for (int i = 0; i < len; i++) begin
            rnd = $urandom;
            frame_buf.push_back(rnd[7:0]);
        end
        rnd = $urandom;
        at  = DPORT_BASE_AT + 4 * ihl;
        if (len > ETYPE_HI_AT) frame_buf[ETYPE_HI_AT] = etype[15:8];
        if (len > ETYPE_LO_AT) frame_buf[ETYPE_LO_AT] = etype[7:0];
        // version nibble stays random, it is not checked
        if (len > IHL_AT)      frame_buf[IHL_AT] = {rnd[7:4], ihl[3:0]};
        if (len > PROTO_AT)    frame_buf[PROTO_AT] = proto;
        if (len > at)          frame_buf[at] = dport[15:8];
        if (len > at + 1)      frame_buf[at + 1] = dport[7:0];
    endfunction

    // send frame_buf in bursts; stray_user puts random queue numbers on all but the last word
    task automatic push_frame(input logic [QID_W-1:0] q, input bit stray_user,
                              input bit typed, input t_result typed_res);
        t_result          res;
        logic [QID_W-1:0] user;
        logic [31:0]      rnd;
        int               gap;
        for (int i = 0; i < frame_buf.size(); i++) begin
            rnd = $urandom;
            if (tx_burst_left == 0) begin
                gap = tx_gapless ? 0 : rnd[18:16] % 7;
                if (gap != 0) begin
                    @(negedge i_clk);
                    s_axis_tvalid = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                tx_burst_left = 1 + rnd[29:24] % 40;
            end
            tx_burst_left--;
            user = (stray_user && i != frame_buf.size() - 1) ? rnd[7:0] : q;
            @(negedge i_clk);
            s_axis_tdata  = frame_buf[i];
            s_axis_tlast  = (i == frame_buf.size() - 1);
            s_axis_tuser  = user;
            s_axis_tvalid = 1'b1;
            do @(posedge i_clk); while (!s_axis_tready);
            if (steer_byte(frame_buf[i], s_axis_tlast, user, res))
                verdict_due.push_back(typed ? typed_res : res);
        end
    endtask

    // stop sending and wait until every verdict is back and the pipeline is empty
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        tx_burst_left = 0;
        while (verdict_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FABRIC_PORT:  port_cfg = val[15:0];
            CFG_BOUND_QUEUES: bound_cfg = val;
            default: ;        // undecoded index, no effect
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_step_row frame_row(input int len, input int ihl, input logic [15:0] etype,
                                            input logic [7:0] proto, input logic [15:0] dport,
                                            input logic [7:0] q, input bit typed,
                                            input logic v, input logic m,
                                            input logic [63:0] cnt);
        t_step_row r;
        r       = '0;
        r.kind  = ROW_FRAME;
        r.len   = len[7:0];
        r.ihl   = ihl[3:0];
        r.etype = etype;
        r.proto = proto;
        r.dport = dport;
        r.queue = q;
        r.typed = typed;
        r.res   = '{match_count: cnt, matched: m, queue: q, verdict: v};
        return r;
    endfunction

    function automatic t_step_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_step_row r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial begin : stim
        t_step_row   row;
        int          frame_no;
        int          rand_bytes;
        int          pick;
        int          ihl;
        int          need;
        int          len;
        logic [15:0] etype;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [7:0]  q;
        logic [31:0] rnd;
        logic [31:0] rnd2;

        // known values on every input from time zero
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        // predictor at reset
        port_cfg  = VXLAN_PORT;
        bound_cfg = '0;
        fr_pos    = '0;
        fr_ihl    = '0;
        fr_flags  = '0;
        foreach (queue_hits[i]) queue_hits[i] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table; rows with typed=1 carry the literal verdict
        //                          len ihl etype       proto      dport             q    t  v  m  cnt
        // reset config: port 4789, no queue bound
        step_rows.push_back(frame_row(1,   5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       0,   1, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       0,   1, 0, 1, 1));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       0,   1, 0, 1, 2));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       63,  1, 0, 1, 1));
        // queue out of range
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       64,  1, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       255, 1, 0, 0, 0));
        // each match condition broken on its own
        step_rows.push_back(frame_row(42,  5, 16'h86dd,   UDP_PROTO, VXLAN_PORT,       1,   1, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, 16'h0801,   UDP_PROTO, VXLAN_PORT,       1,   1, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, 8'd6,      VXLAN_PORT,       1,   1, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT ^ 16'h0100, 1, 1, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT ^ 16'h0001, 1, 1, 0, 0, 0));
        // short frame: one byte below the end of the udp header
        step_rows.push_back(frame_row(41,  5, IPV4_ETYPE, UDP_PROTO, VXLAN_PORT,       1,   1, 0, 0, 0));
        // all queues bound, port 0, undecoded indexes written too
        step_rows.push_back(reg_row(CFG_BOUND_QUEUES, '1));
        step_rows.push_back(reg_row(CFG_FABRIC_PORT, 64'd0));
        step_rows.push_back(reg_row(CFG_SPARE_2, 64'hdead_beef_0123_4567));
        step_rows.push_back(reg_row(CFG_SPARE_3, '1));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, 16'h0000,         0,   1, 1, 1, 3));
        // ihl below 5: minimum length still applies
        step_rows.push_back(frame_row(34,  0, IPV4_ETYPE, UDP_PROTO, 16'h0000,         5,   0, 0, 0, 0));
        step_rows.push_back(frame_row(33,  0, IPV4_ETYPE, UDP_PROTO, 16'h0000,         5,   0, 0, 0, 0));
        step_rows.push_back(frame_row(34,  1, IPV4_ETYPE, UDP_PROTO, 16'h0000,         6,   0, 0, 0, 0));
        // largest ihl, then a frame past the offset saturation
        step_rows.push_back(frame_row(82, 15, IPV4_ETYPE, UDP_PROTO, 16'h0000,         63,  0, 0, 0, 0));
        step_rows.push_back(frame_row(140, 5, IPV4_ETYPE, UDP_PROTO, 16'h0000,         2,   0, 0, 0, 0));
        // top port, alternating mask
        step_rows.push_back(reg_row(CFG_FABRIC_PORT, 64'hffff));
        step_rows.push_back(reg_row(CFG_BOUND_QUEUES, 64'h5555_5555_5555_5555));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, 16'hffff,         1,   0, 0, 0, 0));
        step_rows.push_back(frame_row(42,  5, IPV4_ETYPE, UDP_PROTO, 16'hffff,         2,   0, 0, 0, 0));

        foreach (step_rows[i]) begin
            row = step_rows[i];
            if (row.kind == ROW_REG) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                build_frame(row.len, row.ihl, row.etype, row.proto, row.dport);
                push_frame(row.queue, 1'b0, row.typed, row.res);
            end
        end

        // random frames: mostly well formed with random content, some broken, some noise
        rand_bytes = 0;
        frame_no   = 0;
        while (rand_bytes < RAND_BYTES || frame_no < RAND_FRAMES) begin
            rnd  = $urandom;
            rnd2 = $urandom;

            // new configuration between phases, extremes included
            if (frame_no > 0 && frame_no % CFG_EVERY == 0) begin
                drain_results();
                case (rnd[1:0])
                    2'd0:    write_reg(CFG_FABRIC_PORT, 64'd0);
                    2'd1:    write_reg(CFG_FABRIC_PORT, 64'hffff);
                    2'd2:    write_reg(CFG_FABRIC_PORT, {32'd0, rnd2});
                    default: write_reg(CFG_FABRIC_PORT, {48'd0, VXLAN_PORT});
                endcase
                case (rnd[3:2])
                    2'd0:    write_reg(CFG_BOUND_QUEUES, '0);
                    2'd1:    write_reg(CFG_BOUND_QUEUES, '1);
                    2'd2:    write_reg(CFG_BOUND_QUEUES, {$urandom, $urandom});
                    default: write_reg(CFG_BOUND_QUEUES, 64'h8000_0000_0000_0001);
                endcase
                if (rnd[5:4] == 2'd0)
                    write_reg(rnd[6] ? CFG_SPARE_2 : CFG_SPARE_3, {$urandom, $urandom});
                rnd = $urandom;
            end

            // long receiver hold-off while one-byte frames keep coming
            if (frame_no == HOLD_AT_FRAME) begin
                rx_hold_asks++;
                tx_gapless = 1'b1;
                for (int k = 0; k < 12; k++) begin
                    rnd2 = $urandom;
                    build_frame(1, 0, '0, '0, '0);
                    push_frame(rnd2[8] ? rnd2[7:0] : {6'd0, rnd2[1:0]}, 1'b0, 1'b0, '0);
                    rand_bytes++;
                end
            end

            tx_gapless = (rnd[31:30] == 2'd0);
            pick = rnd[15:8] % 100;
            if (pick < 20) begin
                // noise: short runs of random bytes, queue number wandering
                frame_buf.delete();
                len = 1 + rnd2[4:0] % 24;
                for (int k = 0; k < len; k++) begin
                    rnd2 = $urandom;
                    frame_buf.push_back(rnd2[7:0]);
                end
                rnd2 = $urandom;
                push_frame(rnd2[7:0], 1'b1, 1'b0, '0);
            end else begin
                ihl  = (rnd[23:16] % 100 < 80) ? 5 : rnd2[3:0];
                need = UDP_END_BASE + 4 * ihl;
                if (need < MIN_FRAME)
                    need = MIN_FRAME;
                pick = rnd2[15:8] % 100;
                if (pick < 8)
                    len = need - 1;
                else if (pick < 15)
                    len = need + rnd2[23:16] % (141 - need);
                else
                    len = need + rnd2[23:16] % 17;
                rnd2  = $urandom;
                etype = (rnd2[7:0] % 100 < 92) ? IPV4_ETYPE : rnd2[31:16];
                proto = (rnd2[15:8] % 100 < 92) ? UDP_PROTO : rnd2[23:16];
                rnd2  = $urandom;
                dport = (rnd2[7:0] % 100 < 88) ? port_cfg : rnd2[31:16];
                pick  = rnd2[15:8] % 100;
                // a few hot queues so counter updates land back to back
                if (pick < 70)
                    q = {6'd0, rnd2[17:16]};
                else if (pick < 85)
                    q = {2'd0, rnd2[21:16]};
                else
                    q = 8'(64 + rnd2[23:16] % 192);
                build_frame(len, ihl, etype, proto, dport);
                push_frame(q, 1'b0, 1'b0, '0);
            end
            rand_bytes += frame_buf.size();
            frame_no++;
        end

        drain_results();
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/upqs_pkg.sv
rtl/upqs_parse.sv
rtl/udp_port_queue_steering_core.sv
test/udp_port_queue_steering_core_tb.sv
